// ----- hw/rtl/skvpq_pkg.sv -----
// shared codes and controller command type for the sorted key/value queue
package skvpq_pkg;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_POP_MAX = 2'd1;
  localparam logic [1:0] OP_POP_MIN = 2'd2;
  localparam logic [1:0] OP_LOOKUP  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int unsigned ITEM_WIDTH = 32;

  typedef struct packed {
    logic ld_item;   // capture the incoming beat
    logic ld_flags;  // register per-cell compare results
    logic commit;    // apply the operation and load the result register
  } skvpq_cmd_t;

endpackage

// ----- hw/rtl/skvpq_ctrl.sv -----
// sequencing state machine and result valid flag for the sorted key/value queue
module skvpq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output skvpq_pkg::skvpq_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, commit;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  // exec waits only while the previous result is still held and stalled
  assign commit      = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  assign cmd_o.ld_item  = accept;
  assign cmd_o.ld_flags = (state_q == S_EVAL);
  assign cmd_o.commit   = commit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/skvpq_datapath.sv -----
// sorted cell row with broadcast compare, neighbor shift and result register
module skvpq_datapath #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned CW        = 5
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  skvpq_pkg::skvpq_cmd_t                   cmd_i,
  input  logic [1:0]                              op_i,
  input  logic signed [skvpq_pkg::ITEM_WIDTH-1:0] item_key_i,
  input  logic signed [skvpq_pkg::ITEM_WIDTH-1:0] item_value_i,
  output logic [1:0]                              status_o,
  output logic                                    updated_o,
  output logic signed [skvpq_pkg::ITEM_WIDTH-1:0] out_key_o,
  output logic signed [skvpq_pkg::ITEM_WIDTH-1:0] out_value_o,
  output logic [CW-1:0]                           entry_count_o
);

  localparam int unsigned IW = skvpq_pkg::ITEM_WIDTH;

  logic [1:0]                  op_q;
  logic signed [KEY_WIDTH-1:0] key_q;
  logic signed [IW-1:0]        val_q;
  logic [CW-1:0]               count_q, count_d;

  logic signed [KEY_WIDTH-1:0] keys_q [DEPTH];
  logic signed [IW-1:0]        vals_q [DEPTH];

  logic [DEPTH-1:0] lt_q, eq_q, lt_prev;

  logic [1:0]                  status_d;
  logic                        updated_d;
  logic signed [KEY_WIDTH-1:0] res_key;
  logic signed [IW-1:0]        res_val;
  logic                        add_new, add_upd, pop_min, pop_any;

  logic [1:0]                  status_q;
  logic                        updated_q;
  logic signed [IW-1:0]        out_key_q, out_value_q;
  logic [CW-1:0]               out_count_q;

  // capture the beat, key sign-extended or truncated to the cell width
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      op_q  <= op_i;
      key_q <= KEY_WIDTH'(item_key_i);
      val_q <= item_value_i;
    end
  end

  // broadcast compare against every occupied cell
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_flags) begin
      for (int i = 0; i < DEPTH; i++) begin
        lt_q[i] <= (CW'(i) < count_q) && (keys_q[i] < key_q);
        eq_q[i] <= (CW'(i) < count_q) && (keys_q[i] == key_q);
      end
    end
  end

  assign lt_prev = {lt_q[DEPTH-2:0], 1'b1};

  // hit and last-cell selection as one-hot or-reductions; pop-min reads the first cell directly
  always_comb begin
    res_key = '0;
    res_val = '0;
    unique case (op_q)
      skvpq_pkg::OP_POP_MAX: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == count_q - CW'(1)) begin
            res_key = res_key | keys_q[i];
            res_val = res_val | vals_q[i];
          end
        end
      end
      skvpq_pkg::OP_POP_MIN: begin
        res_key = keys_q[0];
        res_val = vals_q[0];
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (eq_q[i]) begin
            res_key = res_key | keys_q[i];
            res_val = res_val | vals_q[i];
          end
        end
      end
    endcase
  end

  always_comb begin
    status_d  = skvpq_pkg::ST_OK;
    updated_d = 1'b0;
    count_d   = count_q;
    add_new   = 1'b0;
    add_upd   = 1'b0;
    pop_min   = 1'b0;
    pop_any   = 1'b0;
    unique case (op_q) inside
      skvpq_pkg::OP_ADD: begin
        if (|eq_q) begin
          add_upd   = 1'b1;
          updated_d = 1'b1;
        end else if (count_q == CW'(DEPTH)) begin
          status_d = skvpq_pkg::ST_FULL;
        end else begin
          add_new = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      skvpq_pkg::OP_POP_MAX, skvpq_pkg::OP_POP_MIN: begin
        if (count_q == '0) begin
          status_d = skvpq_pkg::ST_EMPTY;
        end else begin
          pop_any = 1'b1;
          pop_min = (op_q == skvpq_pkg::OP_POP_MIN);
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        if (!(|eq_q)) status_d = skvpq_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // each cell takes the new item, its lower neighbor, or its upper neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] up_key, dn_key;
    logic signed [IW-1:0]        up_val, dn_val;
    if (g == 0) begin : g_first
      assign up_key = key_q;
      assign up_val = val_q;
    end else begin : g_rest
      assign up_key = keys_q[g-1];
      assign up_val = vals_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign dn_key = keys_q[g];
      assign dn_val = vals_q[g];
    end else begin : g_below
      assign dn_key = keys_q[g+1];
      assign dn_val = vals_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        if (add_new && !lt_q[g]) begin
          if (lt_prev[g]) begin
            keys_q[g] <= key_q;
            vals_q[g] <= val_q;
          end else begin
            keys_q[g] <= up_key;
            vals_q[g] <= up_val;
          end
        end else if (add_upd && eq_q[g]) begin
          vals_q[g] <= val_q;
        end else if (pop_min) begin
          keys_q[g] <= dn_key;
          vals_q[g] <= dn_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q    <= status_d;
      updated_q   <= updated_d;
      out_key_q   <= (pop_any || (op_q == skvpq_pkg::OP_LOOKUP && (|eq_q)))
                     ? IW'(res_key) : '0;
      out_value_q <= (pop_any || (op_q == skvpq_pkg::OP_LOOKUP && (|eq_q)))
                     ? res_val : '0;
      out_count_q <= count_d;
    end
  end

  assign status_o      = status_q;
  assign updated_o     = updated_q;
  assign out_key_o     = out_key_q;
  assign out_value_o   = out_value_q;
  assign entry_count_o = out_count_q;

endmodule

// ----- hw/rtl/sorted_key_value_priority_queue_core.sv -----
// top level of the sorted key/value priority queue
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+---------------------------------------
//  in      | to core   | in_valid_i / in_stall_o  | op_i, item_key_i, item_value_i
//  out     | from core | out_valid_o / out_stall_i| status_o, updated_o, out_key_o,
//          |           |                         | out_value_o, entry_count_o
//
// each beat goes through capture, compare across all cells, then commit
// commit holds off while the result register is full and out_stall_i is high,
//   so a new beat can be taken while the previous result still waits
// reset clears the entry count, sequencer state and valid flag; cell contents are never read until written
// in_stall_o is high from capture until commit
module sorted_key_value_priority_queue_core #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [1:0]                              op_i,
  input  logic signed [skvpq_pkg::ITEM_WIDTH-1:0] item_key_i,
  input  logic signed [skvpq_pkg::ITEM_WIDTH-1:0] item_value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [1:0]                              status_o,
  output logic                                    updated_o,
  output logic signed [skvpq_pkg::ITEM_WIDTH-1:0] out_key_o,
  output logic signed [skvpq_pkg::ITEM_WIDTH-1:0] out_value_o,
  output logic [$clog2(DEPTH+1)-1:0]              entry_count_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // command bundle from the sequencer into the cell row
  skvpq_pkg::skvpq_cmd_t cmd;

  skvpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // cells keep keys in ascending signed order, compared all at once
  skvpq_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .CW        (CW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (op_i),
    .item_key_i    (item_key_i),
    .item_value_i  (item_value_i),
    .status_o      (status_o),
    .updated_o     (updated_o),
    .out_key_o     (out_key_o),
    .out_value_o   (out_value_o),
    .entry_count_o (entry_count_o)
  );

  // an accepted beat blocks the input until its commit
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after accept");

  // the held count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= CW'(DEPTH)))
    else $error("entry count above depth");

  // full is only reported at full count and empty only at zero
  a_status_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o != skvpq_pkg::ST_FULL || entry_count_o == CW'(DEPTH)) &&
                     (status_o != skvpq_pkg::ST_EMPTY || entry_count_o == '0)))
    else $error("status disagrees with entry count");

  // an overwrite always reports ok
  a_updated_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && updated_o) |-> (status_o == skvpq_pkg::ST_OK))
    else $error("update flagged with error status");

endmodule
